>>> rtl/pru_pkg.sv
// ============================================================================
// Permutation rank/unrank shared definitions
// Word widths, command codes, factorial table and the struct that carries
// the partial unrank state from one pipeline stage to the next.
// ============================================================================
package pru_pkg;

    // Largest supported permutation and the default build size.
    localparam int MAX_ELEMENTS     = 8;
    localparam int DEFAULT_ELEMENTS = 8;

    // Field widths.
    localparam int ELEM_W  = 3;
    localparam int PERM_W  = MAX_ELEMENTS * ELEM_W;
    localparam int INDEX_W = 16;
    localparam int RANK_W  = 16;
    localparam int DIGIT_W = 3;

    // Command codes.
    localparam logic CMD_RANK   = 1'b0;
    localparam logic CMD_UNRANK = 1'b1;

    // Partial unrank state handed from stage to stage.
    typedef struct packed {
        logic [INDEX_W-1:0]      rem;
        logic [MAX_ELEMENTS-1:0] used;
        logic [PERM_W-1:0]       perm;
    } unrank_word_t;

    // Factorial table, k! for k = 0..8.
    function automatic logic [RANK_W-1:0] fact(input int k);
        logic [RANK_W-1:0] f;
        case (k)
            0:       f = 16'd1;
            1:       f = 16'd1;
            2:       f = 16'd2;
            3:       f = 16'd6;
            4:       f = 16'd24;
            5:       f = 16'd120;
            6:       f = 16'd720;
            7:       f = 16'd5040;
            default: f = 16'd40320;
        endcase
        return f;
    endfunction

endpackage

>>> rtl/permutation_rank_unrank_unit.sv
// ============================================================================
// Permutation rank/unrank unit
// Converts a packed permutation to its lexicographic (Lehmer code) rank, or
// an index back to the permutation, one command per clock.
// ============================================================================
// The unit takes a new command in every cycle: busy is never raised, so a
// command is accepted whenever start is high. Each command produces one
// result word, shown for a single cycle with done high, from the output
// register. The unrank pipeline resolves one factorial digit per stage and
// has padding stages when ELEMENTS is below 4; the rank side, made of the
// lane compare, the three-level adder tree and an alignment delay, has the
// same depth. The receiver cannot stall the unit, so it must take every
// word in the cycle done is high. For an unrank index at or above ELEMENTS
// factorial, range_error is set and perm_out is zero; rank_out is zero for
// unrank and perm_out zero for rank.
// ============================================================================
module permutation_rank_unrank_unit
    import pru_pkg::*;
#(
    parameter int ELEMENTS = DEFAULT_ELEMENTS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [PERM_W-1:0]  perm_in,
    input  logic [INDEX_W-1:0] index_in,
    output logic               done,
    output logic [RANK_W-1:0]  rank_out,
    output logic [PERM_W-1:0]  perm_out,
    output logic               range_error
);

    localparam int PIPE = (ELEMENTS > 4) ? ELEMENTS : 4;
    localparam logic [INDEX_W-1:0] LIMIT = fact(ELEMENTS);

    // Lane terms, padded with zero for positions beyond the permutation.
    logic [MAX_ELEMENTS-1:0][RANK_W-1:0] terms;
    logic [RANK_W-1:0]                   rank_sum;

    unrank_word_t stage_word [PIPE+1];

    logic [PIPE-1:0] valid_reg;
    logic [PIPE-1:0] cmd_reg;
    logic [PIPE-1:0] err_reg;

    logic              done_reg;
    logic [RANK_W-1:0] rank_out_reg;
    logic [PERM_W-1:0] perm_out_reg;
    logic              range_error_reg;

    assign busy = 1'b0;

    // Rank lanes, one per element position.
    generate
        for (genvar i = 0; i < MAX_ELEMENTS; i++)
        begin : g_lane
            if (i < ELEMENTS)
            begin : g_used
                pru_rank_lane #(
                    .ELEMENTS (ELEMENTS),
                    .POS      (i)
                ) u_lane (
                    .clk     (clk),
                    .perm_in (perm_in),
                    .term    (terms[i])
                );
            end
            else
            begin : g_zero
                assign terms[i] = '0;
            end
        end
    endgenerate

    pru_merge #(
        .EXTRA (PIPE - 4)
    ) u_merge (
        .clk      (clk),
        .terms    (terms),
        .rank_sum (rank_sum)
    );

    // Unrank pipeline, one digit per stage.
    always_comb
    begin
        stage_word[0].rem  = index_in;
        stage_word[0].used = '0;
        stage_word[0].perm = '0;
    end

    generate
        for (genvar s = 0; s < PIPE; s++)
        begin : g_stage
            pru_unrank_stage #(
                .ELEMENTS (ELEMENTS),
                .POS      (s)
            ) u_stage (
                .clk      (clk),
                .word_in  (stage_word[s]),
                .word_out (stage_word[s+1])
            );
        end
    endgenerate

    // Command tracking: valid flag, command and range check per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= {cmd_reg[PIPE-2:0], cmd};
        err_reg <= {err_reg[PIPE-2:0], (cmd == CMD_UNRANK) && (index_in >= LIMIT)};
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rank_out_reg    <= (cmd_reg[PIPE-1] == CMD_RANK) ? rank_sum : '0;
        perm_out_reg    <= ((cmd_reg[PIPE-1] == CMD_UNRANK) && !err_reg[PIPE-1])
                           ? stage_word[PIPE].perm : '0;
        range_error_reg <= err_reg[PIPE-1];
    end

    assign done        = done_reg;
    assign rank_out    = rank_out_reg;
    assign perm_out    = perm_out_reg;
    assign range_error = range_error_reg;

`ifndef SYNTHESIS
    // Every accepted command yields a result word with done high.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(PIPE+1) done)
        else $error("result word missing after accepted command");

    // An out-of-range index never shows a permutation.
    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && range_error) |-> (perm_out == '0))
        else $error("perm_out not zero on range error");

    // Only one of the two result fields can carry data.
    a_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((rank_out == '0) || (perm_out == '0)))
        else $error("rank_out and perm_out both nonzero");
`endif

endmodule

>>> rtl/pru_rank_lane.sv
// ============================================================================
// Rank lane
// Counts the later elements that are smaller than the element at this
// lane's position and weights the count by the matching factorial.
// ============================================================================
module pru_rank_lane
    import pru_pkg::*;
#(
    parameter int ELEMENTS = DEFAULT_ELEMENTS,
    parameter int POS      = 0
)
(
    input  logic              clk,
    input  logic [PERM_W-1:0] perm_in,
    output logic [RANK_W-1:0] term
);

    localparam logic [RANK_W-1:0] WEIGHT = fact(ELEMENTS - 1 - POS);

    logic [ELEM_W-1:0]  own;
    logic [DIGIT_W-1:0] smaller;
    logic [RANK_W-1:0]  term_next;
    logic [RANK_W-1:0]  term_reg;

    // Compare this element against every later one in parallel.
    always_comb
    begin
        own     = perm_in[ELEM_W*POS +: ELEM_W];
        smaller = '0;
        for (int j = POS + 1; j < ELEMENTS; j++)
        begin
            if (perm_in[ELEM_W*j +: ELEM_W] < own)
            begin
                smaller = smaller + DIGIT_W'(1);
            end
        end
        term_next = RANK_W'(smaller * WEIGHT);
    end

    // Weighted count register.
    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
    end

    assign term = term_reg;

endmodule

>>> rtl/pru_merge.sv
// ============================================================================
// Rank merge tree
// Adds the weighted counts of all lanes in a registered three-level tree
// and delays the sum so that it lines up with the unrank pipeline.
// ============================================================================
module pru_merge
    import pru_pkg::*;
#(
    parameter int EXTRA = 0
)
(
    input  logic                                 clk,
    input  logic [MAX_ELEMENTS-1:0][RANK_W-1:0]  terms,
    output logic [RANK_W-1:0]                    rank_sum
);

    logic [3:0][RANK_W-1:0] lvl1_reg;
    logic [1:0][RANK_W-1:0] lvl2_reg;
    logic [RANK_W-1:0]      lvl3_reg;

    // Pairwise sums, one register per level. The true total never exceeds 8!-1.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            lvl1_reg[k] <= terms[2*k] + terms[2*k+1];
        end
        for (int k = 0; k < 2; k++)
        begin
            lvl2_reg[k] <= lvl1_reg[2*k] + lvl1_reg[2*k+1];
        end
        lvl3_reg <= lvl2_reg[0] + lvl2_reg[1];
    end

    // Alignment delay toward the unrank pipeline depth.
    generate
        if (EXTRA > 0)
        begin : g_delay
            logic [EXTRA-1:0][RANK_W-1:0] dly_reg;

            always_ff @(posedge clk)
            begin
                dly_reg[0] <= lvl3_reg;
                for (int k = 1; k < EXTRA; k++)
                begin
                    dly_reg[k] <= dly_reg[k-1];
                end
            end

            assign rank_sum = dly_reg[EXTRA-1];
        end
        else
        begin : g_direct
            assign rank_sum = lvl3_reg;
        end
    endgenerate

endmodule

>>> rtl/pru_unrank_stage.sv
// ============================================================================
// Unrank stage
// Extracts one factorial-base digit from the remaining index and places
// the matching unused value at this stage's position.
// ============================================================================
module pru_unrank_stage
    import pru_pkg::*;
#(
    parameter int ELEMENTS = DEFAULT_ELEMENTS,
    parameter int POS      = 0
)
(
    input  logic         clk,
    input  unrank_word_t word_in,
    output unrank_word_t word_out
);

    unrank_word_t word_next;
    unrank_word_t word_reg;

    generate
        if (POS < ELEMENTS)
        begin : g_active
            localparam logic [RANK_W-1:0] WEIGHT = fact(ELEMENTS - 1 - POS);

            logic [DIGIT_W-1:0] digit;
            logic [DIGIT_W-1:0] seen;
            logic [ELEM_W-1:0]  pick;
            logic               found;

            always_comb
            begin
                // Digit = number of multiples of the weight not above the remainder.
                digit = '0;
                for (int m = 1; m < MAX_ELEMENTS; m++)
                begin
                    if (word_in.rem >= RANK_W'(m * WEIGHT))
                    begin
                        digit = digit + DIGIT_W'(1);
                    end
                end

                // Select the digit-th value that is still unused.
                seen  = '0;
                pick  = '0;
                found = 1'b0;
                for (int j = 0; j < MAX_ELEMENTS; j++)
                begin
                    if (!word_in.used[j] && !found)
                    begin
                        if (seen == digit)
                        begin
                            pick  = ELEM_W'(j);
                            found = 1'b1;
                        end
                        else
                        begin
                            seen = seen + DIGIT_W'(1);
                        end
                    end
                end

                word_next       = word_in;
                word_next.rem   = word_in.rem - RANK_W'(digit * WEIGHT);
                word_next.used  = word_in.used | (MAX_ELEMENTS'(1) << pick);
                word_next.perm[ELEM_W*POS +: ELEM_W] = pick;
            end
        end
        else
        begin : g_pad
            // Padding stage: only keeps the pipeline depth.
            assign word_next = word_in;
        end
    endgenerate

    // Stage register.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule

>>> dv/pru_checker.sv
// ============================================================================
// Permutation rank/unrank checker
// Watches the command and result words of the unit. It predicts each result
// from its own Lehmer code calculation, keeps the predictions in order, and
// compares every result word field by field with the oldest one.
// ============================================================================
module pru_checker
    import pru_pkg::*;
#(
    parameter int ELEMENTS = DEFAULT_ELEMENTS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               cmd,
    input  logic [PERM_W-1:0]  perm_in,
    input  logic [INDEX_W-1:0] index_in,
    input  logic               done,
    input  logic [RANK_W-1:0]  rank_out,
    input  logic [PERM_W-1:0]  perm_out,
    input  logic               range_error,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted result word.
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [PERM_W-1:0] perm;
        logic              err;
    } result_word_t;

    result_word_t predicted_words[$];

    function automatic int factorial(input int n);
        int r;
        r = 1;
        for (int k = 2; k <= n; k++)
            r = r * k;
        return r;
    endfunction

    // Lexicographic rank: each position weighs the count of later, smaller
    // values by the factorial of the positions left after it.
    function automatic logic [RANK_W-1:0] lehmer_rank(input logic [PERM_W-1:0] p);
        int v [MAX_ELEMENTS];
        int smaller;
        logic [31:0] sum;
        sum = '0;
        for (int i = 0; i < ELEMENTS; i++)
            v[i] = int'(p[ELEM_W*i +: ELEM_W]);
        for (int i = 0; i < ELEMENTS; i++)
        begin
            smaller = 0;
            for (int j = i + 1; j < ELEMENTS; j++)
                if (v[j] < v[i])
                    smaller++;
            sum = sum + smaller * factorial(ELEMENTS - 1 - i);
        end
        return sum[RANK_W-1:0];
    endfunction

    // Index back to permutation: each factorial digit picks the digit-th
    // value that is still unused.
    function automatic logic [PERM_W-1:0] lehmer_unrank(input int idx);
        logic [MAX_ELEMENTS-1:0] taken;
        logic [PERM_W-1:0] p;
        int rem;
        int f;
        int digit;
        int pick;
        bit found;
        taken = '0;
        p = '0;
        rem = idx;
        for (int i = 0; i < ELEMENTS; i++)
        begin
            f = factorial(ELEMENTS - 1 - i);
            digit = rem / f;
            rem = rem % f;
            pick = 0;
            found = 1'b0;
            for (int j = 0; j < MAX_ELEMENTS; j++)
            begin
                if (!found && !taken[j])
                begin
                    if (digit == 0)
                    begin
                        pick = j;
                        found = 1'b1;
                    end
                    else
                        digit--;
                end
            end
            taken[pick] = 1'b1;
            p[ELEM_W*i +: ELEM_W] = pick[ELEM_W-1:0];
        end
        return p;
    endfunction

    function automatic result_word_t predict_word(input logic c,
                                                  input logic [PERM_W-1:0] p,
                                                  input logic [INDEX_W-1:0] idx);
        result_word_t w;
        w = '0;
        if (c == CMD_RANK)
            w.rank = lehmer_rank(p);
        else if (int'(idx) >= factorial(ELEMENTS))
            w.err = 1'b1;
        else
            w.perm = lehmer_unrank(int'(idx));
        return w;
    endfunction

    // Compare results first, then record the newly accepted command word.
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            predicted_words.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (predicted_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected word: rank=%0d perm=%06h err=%0b",
                                 $realtime, rank_out, perm_out, range_error);
                end
                else
                begin
                    want = predicted_words.pop_front();
                    if (rank_out !== want.rank || perm_out !== want.perm
                        || range_error !== want.err)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: expected %0d %06h %0b, got %0d %06h %0b",
                                     $realtime, want.rank, want.perm, want.err,
                                     rank_out, perm_out, range_error);
                    end
                end
            end
            if (start && !busy)
                predicted_words.push_back(predict_word(cmd, perm_in, index_in));
            pending = predicted_words.size();
        end
    end

endmodule

>>> dv/tb_permutation_rank_unrank_unit.sv
// ============================================================================
// Permutation rank/unrank unit testbench
// Drives directed and random rank and unrank command words into the unit
// under varying sender gaps; the checker beside it predicts and compares
// every result word, and this top gives the verdict.
// ============================================================================
module tb_permutation_rank_unrank_unit;
    import pru_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELEMENTS    = 8;
    localparam int FACT_N      = 40320;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cmd;
    logic [PERM_W-1:0]  perm_in;
    logic [INDEX_W-1:0] index_in;
    logic               done;
    logic [RANK_W-1:0]  rank_out;
    logic [PERM_W-1:0]  perm_out;
    logic               range_error;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    int                 idle_pct;

    permutation_rank_unrank_unit #(.ELEMENTS(ELEMENTS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .perm_in(perm_in), .index_in(index_in), .done(done),
        .rank_out(rank_out), .perm_out(perm_out), .range_error(range_error)
    );

    pru_checker #(.ELEMENTS(ELEMENTS)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .perm_in(perm_in), .index_in(index_in), .done(done),
        .rank_out(rank_out), .perm_out(perm_out), .range_error(range_error),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Packed permutation with element i at position i, or reversed.
    function automatic logic [PERM_W-1:0] ordered_perm(input bit reversed);
        logic [PERM_W-1:0] p;
        p = '0;
        for (int i = 0; i < ELEMENTS; i++)
            p[ELEM_W*i +: ELEM_W] = reversed ? ELEM_W'(ELEMENTS - 1 - i) : ELEM_W'(i);
        return p;
    endfunction

    // Random true permutation by a Fisher-Yates shuffle.
    function automatic logic [PERM_W-1:0] shuffled_perm();
        int a [MAX_ELEMENTS];
        int k;
        int t;
        logic [PERM_W-1:0] p;
        p = '0;
        for (int i = 0; i < ELEMENTS; i++)
            a[i] = i;
        for (int i = ELEMENTS - 1; i > 0; i--)
        begin
            k = $urandom_range(0, i);
            t = a[i];
            a[i] = a[k];
            a[k] = t;
        end
        for (int i = 0; i < ELEMENTS; i++)
            p[ELEM_W*i +: ELEM_W] = ELEM_W'(a[i]);
        return p;
    endfunction

    // Present one command word and hold it until the unit takes it.
    task automatic send_word(input logic c, input logic [PERM_W-1:0] p,
                             input logic [INDEX_W-1:0] idx);
        start <= 1'b1;
        cmd <= c;
        perm_in <= p;
        index_in <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Hold off new words until every outstanding result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_word(CMD_RANK, shuffled_perm(), INDEX_W'($urandom_range(0, 65535)));
        else if (r < 50)
            send_word(CMD_RANK, PERM_W'($urandom()), INDEX_W'($urandom_range(0, 65535)));
        else if (r < 90)
            send_word(CMD_UNRANK, PERM_W'($urandom()),
                      INDEX_W'($urandom_range(0, FACT_N - 1)));
        else
            send_word(CMD_UNRANK, PERM_W'($urandom()),
                      INDEX_W'($urandom_range(FACT_N, 65535)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_RANK;
        perm_in = '0;
        index_in = '0;
        idle_pct = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words: ordered and reversed permutations, values that
        // repeat or are all equal, and unrank indexes at and past the range.
        send_word(CMD_RANK, ordered_perm(1'b0), 16'h0000);
        send_word(CMD_RANK, ordered_perm(1'b1), 16'hFFFF);
        send_word(CMD_RANK, 24'h000000, 16'hAAAA);
        send_word(CMD_RANK, 24'hFFFFFF, 16'h5555);
        send_word(CMD_RANK, 24'hAAAAAA, 16'h0000);
        send_word(CMD_RANK, 24'h555555, 16'hFFFF);
        send_word(CMD_RANK, 24'h0F0F0F, 16'h1234);
        send_word(CMD_RANK, shuffled_perm(), 16'h0000);
        send_word(CMD_RANK, shuffled_perm(), 16'hFFFF);
        send_word(CMD_UNRANK, 24'hFFFFFF, 16'd0);
        send_word(CMD_UNRANK, 24'h000000, 16'd1);
        send_word(CMD_UNRANK, 24'hAAAAAA, 16'd5039);
        send_word(CMD_UNRANK, 24'h555555, 16'd5040);
        send_word(CMD_UNRANK, 24'h000000, 16'd40319);
        send_word(CMD_UNRANK, 24'hFFFFFF, 16'd40320);
        send_word(CMD_UNRANK, 24'h000000, 16'hFFFF);
        send_word(CMD_UNRANK, 24'h000000, 16'h5555);
        send_word(CMD_UNRANK, 24'h000000, 16'hAAAA);
        send_word(CMD_UNRANK, 24'h000000, 16'h8000);
        send_word(CMD_UNRANK, 24'h000000, 16'd720);
        wait_drained();

        // Random words in three phases of sender idling.
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 19 : (phase == 1) ? 60 : 0;
            for (int n = 0; n < 200; n++)
                send_random_word();
            wait_drained();
        end

        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
